FILE: design/tbwd_pkg.sv
// ----------------------------------------------------------------------------
// tbwd_pkg: shared types and codes for the trigger bank word deframer
// Section codes, result tags, status codes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package tbwd_pkg;

	localparam int MAX_MUONS_DEF   = 8;
	localparam int QUEUE_DEPTH_DEF = 2;

	// decode sections; the two extra kinds only travel in the queue
	localparam logic [4:0] S_IDLE       = 5'd0;
	localparam logic [4:0] S_MUHDR      = 5'd1;
	localparam logic [4:0] S_MUPT       = 5'd2;
	localparam logic [4:0] S_MUADD12    = 5'd3;
	localparam logic [4:0] S_MUADD3     = 5'd4;
	localparam logic [4:0] S_MUIN_ADD   = 5'd5;
	localparam logic [4:0] S_MUIN_PT    = 5'd6;
	localparam logic [4:0] S_PGA2HDR    = 5'd7;
	localparam logic [4:0] S_PREDEC     = 5'd8;
	localparam logic [4:0] S_DEC        = 5'd9;
	localparam logic [4:0] S_COND       = 5'd10;
	localparam logic [4:0] S_CALO0      = 5'd11;
	localparam logic [4:0] S_CALO1      = 5'd12;
	localparam logic [4:0] S_CALO2      = 5'd13;
	localparam logic [4:0] S_CALO3      = 5'd14;
	localparam logic [4:0] S_CALO4      = 5'd15;
	localparam logic [4:0] S_CALO5      = 5'd16;
	localparam logic [4:0] S_PREV_DEC   = 5'd17;
	localparam logic [4:0] S_PREV_COND  = 5'd18;
	localparam logic [4:0] S_PREV_SUMET = 5'd19;
	localparam logic [4:0] S_NEXT_DEC   = 5'd20;
	localparam logic [4:0] S_NEXT_COND  = 5'd21;
	localparam logic [4:0] S_NEXT_SUMET = 5'd22;
	localparam logic [4:0] K_HDR        = 5'd23;
	localparam logic [4:0] K_ERR        = 5'd24;

	localparam logic [5:0] TG_TRIG_COUNT    = 6'd0;
	localparam logic [5:0] TG_COND_COUNT    = 6'd1;
	localparam logic [5:0] TG_PGA_VERSION   = 6'd2;
	localparam logic [5:0] TG_PREV_COUNT    = 6'd3;
	localparam logic [5:0] TG_NEXT_COUNT    = 6'd4;
	localparam logic [5:0] TG_TCK           = 6'd5;
	localparam logic [5:0] TG_CU0           = 6'd6;
	localparam logic [5:0] TG_CU1           = 6'd7;
	localparam logic [5:0] TG_CU2           = 6'd8;
	localparam logic [5:0] TG_CU3           = 6'd9;
	localparam logic [5:0] TG_BCID_MUON     = 6'd10;
	localparam logic [5:0] TG_MUON_COUNT    = 6'd11;
	localparam logic [5:0] TG_MU1_PT        = 6'd12;
	localparam logic [5:0] TG_MU1_SGN       = 6'd13;
	localparam logic [5:0] TG_MU2_PT        = 6'd14;
	localparam logic [5:0] TG_MU2_SGN       = 6'd15;
	localparam logic [5:0] TG_MU3_PT        = 6'd16;
	localparam logic [5:0] TG_MU3_SGN       = 6'd17;
	localparam logic [5:0] TG_DIMU_PT       = 6'd18;
	localparam logic [5:0] TG_DIMU_PROD     = 6'd19;
	localparam logic [5:0] TG_MU1_ADD       = 6'd20;
	localparam logic [5:0] TG_MU2_ADD       = 6'd21;
	localparam logic [5:0] TG_MU3_ADD       = 6'd22;
	localparam logic [5:0] TG_CLEAN         = 6'd23;
	localparam logic [5:0] TG_MUIN_ADD      = 6'd24;
	localparam logic [5:0] TG_MUIN_PT       = 6'd25;
	localparam logic [5:0] TG_MUIN_SGN      = 6'd26;
	localparam logic [5:0] TG_PGA2_STATUS   = 6'd27;
	localparam logic [5:0] TG_DECISION_BITS = 6'd28;
	localparam logic [5:0] TG_BCID          = 6'd29;
	localparam logic [5:0] TG_BANK_SIZE     = 6'd30;
	localparam logic [5:0] TG_PREDEC_SUM    = 6'd31;
	localparam logic [5:0] TG_DEC_SUM       = 6'd32;
	localparam logic [5:0] TG_COND_SUM      = 6'd33;
	localparam logic [5:0] TG_SUM_ET        = 6'd34;
	localparam logic [5:0] TG_SPD_MULT      = 6'd35;
	localparam logic [5:0] TG_PU_MORE       = 6'd36;
	localparam logic [5:0] TG_E_ET          = 6'd37;
	localparam logic [5:0] TG_G_ET          = 6'd38;
	localparam logic [5:0] TG_GPI0_ET       = 6'd39;
	localparam logic [5:0] TG_LPI0_ET       = 6'd40;
	localparam logic [5:0] TG_H_ET          = 6'd41;
	localparam logic [5:0] TG_PU_PEAK1      = 6'd42;
	localparam logic [5:0] TG_PU_PEAK2      = 6'd43;
	localparam logic [5:0] TG_PU_HITS       = 6'd44;
	localparam logic [5:0] TG_E_ADD         = 6'd45;
	localparam logic [5:0] TG_G_ADD         = 6'd46;
	localparam logic [5:0] TG_GPI0_ADD      = 6'd47;
	localparam logic [5:0] TG_LPI0_ADD      = 6'd48;
	localparam logic [5:0] TG_H_ADD         = 6'd49;
	localparam logic [5:0] TG_PU_PEAK1_POS  = 6'd50;
	localparam logic [5:0] TG_PU_PEAK2_POS  = 6'd51;
	localparam logic [5:0] TG_ERROR         = 6'd52;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_VERSION  = 3'd1;
	localparam logic [2:0] ST_MUONS    = 3'd2;
	localparam logic [2:0] ST_SIZE     = 3'd3;
	localparam logic [2:0] ST_BCID     = 3'd4;

	localparam logic [7:0] GOOD_VERSION = 8'd2;

	// one classified word, with the context the back end needs to expand it
	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] word;
		logic [3:0]  sub;
		logic [2:0]  xc;
		logic [1:0]  tc;
		logic [1:0]  cc;
		logic [1:0]  pc;
		logic [1:0]  nc;
		logic [3:0]  mc;
		logic [6:0]  bcid;
		logic [15:0] len;
		logic [11:0] ids;
		logic [2:0]  err;
	} tbwd_entry_t;

	typedef struct packed {
		logic [5:0]  tag;
		logic [31:0] value;
		logic [2:0]  slot;
		logic [2:0]  crossing;
		logic [2:0]  status;
	} tbwd_res_t;

endpackage

FILE: design/trigger_bank_word_deframer_top.sv
// ----------------------------------------------------------------------------
// trigger_bank_word_deframer_top: trigger decision bank word deframer
// Splits a version-2 trigger decision bank, one 32-bit word per transfer,
// into tagged field records with bank size and BCID checks.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: word, bank_bytes, bank_version
//                                  s_tuser: first_word
// m_       out  m_tvalid/m_tready  m_tdata: field_tag, field_value, slot,
//                                  crossing, status; m_tlast: last
//
// A word makes 1 to 8 records; the back end's output register sends one record
// per cycle unless m_tready stalls it, and so sets the sustained rate.
// A word is classified by the front end, then passes the queue, the back end's
// entry register and its output register on the way to its first record.
// arst_n clears section state, queue pointers and output valid.
// The front end keeps taking words while the back end or m_tready stalls,
// until the queue between them is full.
// ----------------------------------------------------------------------------
module trigger_bank_word_deframer_top import tbwd_pkg::*; #(
	parameter int MAX_MUONS   = MAX_MUONS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // [31:0] word, [47:32] bank_bytes, [55:48] bank_version
	input  logic        s_tuser,   // [0] first_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [5:0] field_tag, [37:6] field_value, [40:38] slot,
	                               // [43:41] crossing, [46:44] status, [47] zero
	output logic        m_tlast
);

	// front end to queue
	logic        fq_valid, fq_ready;
	tbwd_entry_t fq_entry;
	// queue to back end
	logic        qb_valid, qb_ready;
	tbwd_entry_t qb_entry;
	tbwd_res_t   res;

	tbwd_front #(
		.MAX_MUONS (MAX_MUONS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.word         (s_tdata[31:0]),
		.first_word   (s_tuser),
		.bank_bytes   (s_tdata[47:32]),
		.bank_version (s_tdata[55:48]),
		.q_valid      (fq_valid),
		.q_ready      (fq_ready),
		.q_entry      (fq_entry)
	);

	// decouples word classification from record output
	tbwd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_entry),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_entry)
	);

	tbwd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_data  (qb_entry),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.out_last  (m_tlast)
	);

	assign m_tdata = {1'b0, res.status, res.crossing, res.slot, res.value, res.tag};

endmodule

FILE: design/tbwd_queue.sv
// ----------------------------------------------------------------------------
// tbwd_queue: short entry queue between front and back end
// Register-based FIFO of classified words.
// ----------------------------------------------------------------------------
module tbwd_queue import tbwd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  tbwd_entry_t push_data,
	output logic        pop_valid,
	input  logic        pop_ready,
	output tbwd_entry_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tbwd_entry_t     mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            push, pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/tbwd_front.sv
// ----------------------------------------------------------------------------
// tbwd_front: word classifier
// Tracks the bank section, counts and muon ids; one word per cycle while the queue has room.
// ----------------------------------------------------------------------------
module tbwd_front import tbwd_pkg::*; #(
	parameter int MAX_MUONS = MAX_MUONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] word,
	input  logic        first_word,
	input  logic [15:0] bank_bytes,
	input  logic [7:0]  bank_version,
	output logic        q_valid,
	input  logic        q_ready,
	output tbwd_entry_t q_entry
);

	localparam int IDN = (MAX_MUONS < 4) ? 4 : MAX_MUONS;

	logic [4:0]  sec_q, sec_n;
	logic [3:0]  sub_q, sub_n;
	logic [2:0]  xc_q, xc_n;
	logic [1:0]  tc_q, cc_q, pc_q, nc_q, tc_n, cc_n, pc_n, nc_n;
	logic [3:0]  mc_q, mc_n;
	logic [6:0]  bcid_q, bcid_n;
	logic [15:0] len_q, len_n;
	logic [2:0]  ids_q [IDN];
	logic        fire, do_enter;
	logic [4:0]  ent_s;
	logic [2:0]  ent_x;
	logic [7:0]  ent_r;
	logic [4:0]  k0, k1;
	logic        wr_ids, shift_ids;

	// resolve a section entry, skipping sections that take no words
	function automatic logic [7:0] enter_f(input logic [4:0] s0, input logic [2:0] x0,
			input logic [1:0] tc, input logic [1:0] cc, input logic [1:0] pc,
			input logic [1:0] nc, input logic [3:0] mc);
		logic [4:0] s;
		logic [2:0] x;
		logic       done;
		s    = s0;
		x    = x0;
		done = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!done) begin
				unique case (s)
					S_MUIN_ADD, S_MUIN_PT: begin
						if (mc == '0) s = S_PGA2HDR; else done = 1'b1;
					end
					S_PREDEC: begin
						if (tc == '0) s = S_DEC; else done = 1'b1;
					end
					S_DEC: begin
						if (tc == '0) s = S_COND; else done = 1'b1;
					end
					S_COND: begin
						if (cc == '0) s = S_CALO0; else done = 1'b1;
					end
					S_PREV_DEC: begin
						if (x == '0) begin
							s = S_PREV_SUMET;
						end else if (tc == '0 && cc == '0) begin
							x = '0;
							s = S_PREV_SUMET;
						end else if (tc == '0) begin
							s = S_PREV_COND;
						end else begin
							done = 1'b1;
						end
					end
					S_PREV_COND: begin
						if (cc == '0) begin
							x = x - 1'b1;
							s = S_PREV_DEC;
						end else begin
							done = 1'b1;
						end
					end
					S_PREV_SUMET: begin
						if (pc == '0) begin
							x = 3'd1;
							s = S_NEXT_DEC;
						end else begin
							done = 1'b1;
						end
					end
					S_NEXT_DEC: begin
						if (x > {1'b0, nc}) begin
							s = S_NEXT_SUMET;
						end else if (tc == '0 && cc == '0) begin
							x = {1'b0, nc} + 3'd1;
							s = S_NEXT_SUMET;
						end else if (tc == '0) begin
							s = S_NEXT_COND;
						end else begin
							done = 1'b1;
						end
					end
					S_NEXT_COND: begin
						if (cc == '0) begin
							x = x + 1'b1;
							s = S_NEXT_DEC;
						end else begin
							done = 1'b1;
						end
					end
					S_NEXT_SUMET: begin
						if (nc == '0) s = S_IDLE;
						done = 1'b1;
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end
		end
		return {s, x};
	endfunction

	// every word that is not dropped while idle makes at least one result
	assign q_valid  = in_valid && (first_word || sec_q != S_IDLE);
	assign in_ready = q_ready;
	assign fire     = in_valid && in_ready;

	assign k0 = {sub_q, 1'b0};
	assign k1 = {sub_q, 1'b1};

	always_comb begin
		sec_n    = sec_q;
		sub_n    = sub_q;
		xc_n     = xc_q;
		tc_n     = tc_q;
		cc_n     = cc_q;
		pc_n     = pc_q;
		nc_n     = nc_q;
		mc_n     = mc_q;
		bcid_n   = bcid_q;
		len_n    = len_q;
		do_enter = 1'b0;
		ent_s    = sec_q;
		ent_x    = xc_q;

		q_entry      = '0;
		q_entry.kind = sec_q;
		q_entry.word = word;
		q_entry.sub  = sub_q;
		q_entry.xc   = xc_q;
		q_entry.tc   = tc_q;
		q_entry.cc   = cc_q;
		q_entry.pc   = pc_q;
		q_entry.nc   = nc_q;
		q_entry.mc   = mc_q;
		q_entry.bcid = bcid_q;
		q_entry.len  = len_q;
		q_entry.ids  = {ids_q[3], ids_q[2], ids_q[1], ids_q[0]};
		q_entry.err  = ST_OK;

		if (first_word) begin
			len_n = bank_bytes;
			if (bank_version != GOOD_VERSION) begin
				q_entry.kind = K_ERR;
				q_entry.word = 32'(bank_version);
				q_entry.err  = ST_VERSION;
				sec_n        = S_IDLE;
			end else begin
				q_entry.kind = K_HDR;
				tc_n  = word[1:0];
				cc_n  = word[3:2];
				pc_n  = word[13:12];
				nc_n  = word[15:14];
				mc_n  = '0;
				sub_n = '0;
				xc_n  = '0;
				sec_n = S_MUHDR;
			end
		end else begin
			unique case (sec_q)
				S_MUHDR: begin
					if (word[31:28] > 4'(MAX_MUONS)) begin
						q_entry.kind = K_ERR;
						q_entry.word = 32'(word[31:28]);
						q_entry.err  = ST_MUONS;
						sec_n        = S_IDLE;
					end else begin
						mc_n   = word[31:28];
						bcid_n = word[27:21];
						sec_n  = S_MUPT;
					end
				end
				S_MUPT:    sec_n = S_MUADD12;
				S_MUADD12: sec_n = S_MUADD3;
				S_MUADD3: begin
					do_enter = 1'b1;
					ent_s    = S_MUIN_ADD;
				end
				S_MUIN_ADD: begin
					sub_n = sub_q + 1'b1;
					if ({sub_n, 1'b0} >= {1'b0, mc_q}) begin
						do_enter = 1'b1;
						ent_s    = S_MUIN_PT;
					end
				end
				S_MUIN_PT: begin
					sub_n = sub_q + 1'b1;
					if ({sub_n, 2'b00} >= {2'b00, mc_q}) begin
						do_enter = 1'b1;
						ent_s    = S_PGA2HDR;
					end
				end
				S_PGA2HDR: begin
					do_enter = 1'b1;
					ent_s    = S_PREDEC;
				end
				S_PREDEC, S_DEC: begin
					sub_n = sub_q + 1'b1;
					if (sub_n >= {2'b00, tc_q}) begin
						do_enter = 1'b1;
						ent_s    = sec_q + 1'b1;
					end
				end
				S_COND: begin
					sub_n = sub_q + 1'b1;
					if (sub_n >= {2'b00, cc_q}) begin
						do_enter = 1'b1;
						ent_s    = S_CALO0;
					end
				end
				S_CALO0: sec_n = S_CALO1;
				S_CALO1: sec_n = S_CALO2;
				S_CALO2: sec_n = S_CALO3;
				S_CALO3: sec_n = S_CALO4;
				S_CALO4: sec_n = S_CALO5;
				S_CALO5: begin
					do_enter = 1'b1;
					ent_s    = S_PREV_DEC;
					ent_x    = {1'b0, pc_q};
				end
				S_PREV_DEC, S_NEXT_DEC: begin
					sub_n = sub_q + 1'b1;
					if (sub_n >= {2'b00, tc_q}) begin
						do_enter = 1'b1;
						ent_s    = sec_q + 1'b1;
					end
				end
				S_PREV_COND: begin
					sub_n = sub_q + 1'b1;
					if (sub_n >= {2'b00, cc_q}) begin
						do_enter = 1'b1;
						ent_s    = S_PREV_DEC;
						ent_x    = xc_q - 1'b1;
					end
				end
				S_NEXT_COND: begin
					sub_n = sub_q + 1'b1;
					if (sub_n >= {2'b00, cc_q}) begin
						do_enter = 1'b1;
						ent_s    = S_NEXT_DEC;
						ent_x    = xc_q + 1'b1;
					end
				end
				S_PREV_SUMET: begin
					sub_n = sub_q + 1'b1;
					if ({sub_n, 1'b0} >= {3'b000, pc_q}) begin
						do_enter = 1'b1;
						ent_s    = S_NEXT_DEC;
						ent_x    = 3'd1;
					end
				end
				S_NEXT_SUMET: begin
					sub_n = sub_q + 1'b1;
					if ({sub_n, 1'b0} >= {3'b000, nc_q}) sec_n = S_IDLE;
				end
				default: ;
			endcase
		end

		ent_r = enter_f(ent_s, ent_x, tc_n, cc_n, pc_n, nc_n, mc_n);
		if (do_enter) begin
			sec_n = ent_r[7:3];
			xc_n  = ent_r[2:0];
			sub_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= S_IDLE;
			sub_q  <= '0;
			xc_q   <= '0;
			tc_q   <= '0;
			cc_q   <= '0;
			pc_q   <= '0;
			nc_q   <= '0;
			mc_q   <= '0;
			bcid_q <= '0;
			len_q  <= '0;
		end else if (fire) begin
			sec_q  <= sec_n;
			sub_q  <= sub_n;
			xc_q   <= xc_n;
			tc_q   <= tc_n;
			cc_q   <= cc_n;
			pc_q   <= pc_n;
			nc_q   <= nc_n;
			mc_q   <= mc_n;
			bcid_q <= bcid_n;
			len_q  <= len_n;
		end
	end

	// muon id lanes: filled two per address word, drained four per pt word
	assign wr_ids    = fire && !first_word && (sec_q == S_MUIN_ADD);
	assign shift_ids = fire && !first_word && (sec_q == S_MUIN_PT);

	for (genvar j = 0; j < IDN; j++) begin : g_ids
		always_ff @(posedge clk) begin
			if (wr_ids) begin
				if (k0 == 5'(j) && k0 < {1'b0, mc_q}) begin
					ids_q[j] <= word[15:13];
				end else if (k1 == 5'(j) && k1 < {1'b0, mc_q}) begin
					ids_q[j] <= word[31:29];
				end
			end else if (shift_ids) begin
				if (j + 4 < IDN) begin
					ids_q[j] <= ids_q[(j + 4) % IDN];
				end
			end
		end
	end

endmodule

FILE: design/tbwd_back.sv
// ----------------------------------------------------------------------------
// tbwd_back: result expander
// Turns one queued word into its field records, one record per cycle unless out_ready stalls.
// ----------------------------------------------------------------------------
module tbwd_back import tbwd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  tbwd_entry_t pop_data,
	output logic        out_valid,
	input  logic        out_ready,
	output tbwd_res_t   out_res,
	output logic        out_last
);

	tbwd_entry_t cur_q;
	logic        cur_v_q;
	logic [3:0]  idx_q;
	logic [3:0]  cnt_w;
	tbwd_res_t   res_w;
	logic        emit, fin;
	logic        out_v_q, out_last_q;
	tbwd_res_t   out_res_q;

	function automatic logic [3:0] cnt_f(input tbwd_entry_t e);
		logic [4:0] rem2, rem4, remp, remn;
		rem2 = {1'b0, e.mc} - {e.sub, 1'b0};
		rem4 = {1'b0, e.mc} - {e.sub[2:0], 2'b00};
		remp = {3'b000, e.pc} - {e.sub, 1'b0};
		remn = {3'b000, e.nc} - {e.sub, 1'b0};
		unique case (e.kind)
			K_HDR, S_MUHDR:               return 4'd6;
			S_MUPT:                       return 4'd8;
			S_MUADD12, S_MUADD3:          return 4'd2;
			S_CALO3, S_CALO4:             return 4'd2;
			S_CALO0, S_CALO5:             return 4'd3;
			S_PGA2HDR, S_CALO1, S_CALO2:  return 4'd4;
			S_MUIN_ADD:   return (rem2 >= 5'd2) ? 4'd2 : rem2[3:0];
			S_MUIN_PT:    return (rem4 >= 5'd4) ? 4'd8 : {rem4[2:0], 1'b0};
			S_PREV_SUMET: return (remp >= 5'd2) ? 4'd2 : remp[3:0];
			S_NEXT_SUMET: return (remn >= 5'd2) ? 4'd2 : remn[3:0];
			default:                      return 4'd1;
		endcase
	endfunction

	function automatic logic [15:0] size_f(input tbwd_entry_t e);
		logic [15:0] tc, cc, pc, nc, mc, a, b;
		tc = 16'(e.tc);
		cc = 16'(e.cc);
		pc = 16'(e.pc);
		nc = 16'(e.nc);
		mc = 16'(e.mc);
		a  = 16'd7 + cc + (tc << 1) + ((tc + cc) * (pc + nc))
			+ ((pc + 16'd1) >> 1) + ((nc + 16'd1) >> 1);
		b  = 16'd4 + ((mc + 16'd3) >> 2) + ((mc + 16'd1) >> 1);
		return 16'd4 + (a << 2) + (b << 2);
	endfunction

	function automatic tbwd_res_t res_f(input tbwd_entry_t e, input logic [3:0] i);
		tbwd_res_t   r;
		logic [31:0] w;
		logic [15:0] half;
		logic [7:0]  byt;
		logic [7:0]  byt4;
		logic [11:0] bcid;
		logic [15:0] sz;
		logic [3:0]  k;
		logic [13:0] prod;
		w    = e.word;
		half = i[0] ? w[31:16] : w[15:0];
		byt  = 8'(w >> {i[2:1], 3'b000});
		byt4 = 8'(w >> {i[1:0], 3'b000});
		bcid = {w[29:28], w[9:0]};
		sz   = size_f(e);
		k    = {e.sub[2:0], i[0]};
		prod = 14'(w[6:0]) * 14'(w[14:8]);
		r    = '0;
		unique case (e.kind)
			K_ERR: begin
				r.tag    = TG_ERROR;
				r.value  = w;
				r.status = e.err;
			end
			K_HDR: begin
				unique case (i)
					4'd0:    begin r.tag = TG_TRIG_COUNT;  r.value = 32'(w[1:0]);   end
					4'd1:    begin r.tag = TG_COND_COUNT;  r.value = 32'(w[3:2]);   end
					4'd2:    begin r.tag = TG_PGA_VERSION; r.value = 32'(w[11:4]);  end
					4'd3:    begin r.tag = TG_PREV_COUNT;  r.value = 32'(w[13:12]); end
					4'd4:    begin r.tag = TG_NEXT_COUNT;  r.value = 32'(w[15:14]); end
					default: begin r.tag = TG_TCK;         r.value = 32'(w[31:16]); end
				endcase
			end
			S_MUHDR: begin
				unique case (i)
					4'd0:    begin r.tag = TG_CU0;        r.value = 32'(w[3:0]);   end
					4'd1:    begin r.tag = TG_CU1;        r.value = 32'(w[7:4]);   end
					4'd2:    begin r.tag = TG_CU2;        r.value = 32'(w[11:8]);  end
					4'd3:    begin r.tag = TG_CU3;        r.value = 32'(w[15:12]); end
					4'd4:    begin r.tag = TG_BCID_MUON;  r.value = 32'(w[27:21]); end
					default: begin r.tag = TG_MUON_COUNT; r.value = 32'(w[31:28]); end
				endcase
			end
			S_MUPT: begin
				unique case (i)
					4'd0: begin r.tag = TG_MU1_PT;  r.value = 32'(w[6:0]);   end
					4'd1: begin r.tag = TG_MU1_SGN; r.value = 32'(w[7]);     end
					4'd2: begin r.tag = TG_MU2_PT;  r.value = 32'(w[14:8]);  end
					4'd3: begin r.tag = TG_MU2_SGN; r.value = 32'(w[15]);    end
					4'd4: begin r.tag = TG_MU3_PT;  r.value = 32'(w[22:16]); end
					4'd5: begin r.tag = TG_MU3_SGN; r.value = 32'(w[23]);    end
					4'd6: begin r.tag = TG_DIMU_PT; r.value = 32'(w[31:24]); end
					default: begin
						r.tag   = TG_DIMU_PROD;
						r.value = 32'(prod);
					end
				endcase
			end
			S_MUADD12: begin
				r.tag   = i[0] ? TG_MU2_ADD : TG_MU1_ADD;
				r.value = 32'(half);
			end
			S_MUADD3: begin
				r.tag   = i[0] ? TG_CLEAN : TG_MU3_ADD;
				r.value = i[0] ? 32'(w[23:16]) : 32'(w[15:0]);
			end
			S_MUIN_ADD: begin
				r.tag   = TG_MUIN_ADD;
				r.value = 32'(half);
				r.slot  = half[15:13];
			end
			S_MUIN_PT: begin
				r.tag   = i[0] ? TG_MUIN_SGN : TG_MUIN_PT;
				r.value = i[0] ? 32'(byt[7]) : 32'(byt[6:0]);
				r.slot  = 3'(e.ids >> ({1'b0, i[2:1], 1'b0} + {2'b00, i[2:1]}));
			end
			S_PGA2HDR: begin
				unique case (i)
					4'd0: begin r.tag = TG_PGA2_STATUS;   r.value = 32'(w[27:16]); end
					4'd1: begin r.tag = TG_DECISION_BITS; r.value = 32'(w[14:10]); end
					4'd2: begin
						r.tag    = TG_BCID;
						r.value  = 32'(bcid);
						r.status = (bcid[6:0] != e.bcid) ? ST_BCID : ST_OK;
					end
					default: begin
						r.tag    = TG_BANK_SIZE;
						r.value  = 32'(sz);
						r.status = (sz != e.len) ? ST_SIZE : ST_OK;
					end
				endcase
			end
			S_PREDEC: begin r.tag = TG_PREDEC_SUM; r.value = w; r.slot = e.sub[2:0]; end
			S_DEC:    begin r.tag = TG_DEC_SUM;    r.value = w; r.slot = e.sub[2:0]; end
			S_COND:   begin r.tag = TG_COND_SUM;   r.value = w; r.slot = e.sub[2:0]; end
			S_PREV_DEC, S_PREV_COND: begin
				r.tag      = (e.kind == S_PREV_DEC) ? TG_DEC_SUM : TG_COND_SUM;
				r.value    = w;
				r.slot     = e.sub[2:0];
				r.crossing = 3'd0 - e.xc;
			end
			S_NEXT_DEC, S_NEXT_COND: begin
				r.tag      = (e.kind == S_NEXT_DEC) ? TG_DEC_SUM : TG_COND_SUM;
				r.value    = w;
				r.slot     = e.sub[2:0];
				r.crossing = e.xc;
			end
			S_CALO0: begin
				unique case (i)
					4'd0:    begin r.tag = TG_SUM_ET;   r.value = 32'(w[13:0]);  end
					4'd1:    begin r.tag = TG_SPD_MULT; r.value = 32'(w[27:14]); end
					default: begin r.tag = TG_PU_MORE;  r.value = 32'(w[31:28]); end
				endcase
			end
			S_CALO1, S_CALO2: begin
				r.value = 32'(byt4);
				unique case (i)
					4'd0:    r.tag = (e.kind == S_CALO1) ? TG_E_ET : TG_H_ET;
					4'd1:    r.tag = (e.kind == S_CALO1) ? TG_G_ET : TG_PU_PEAK1;
					4'd2:    r.tag = (e.kind == S_CALO1) ? TG_GPI0_ET : TG_PU_PEAK2;
					default: r.tag = (e.kind == S_CALO1) ? TG_LPI0_ET : TG_PU_HITS;
				endcase
			end
			S_CALO3: begin
				r.tag   = i[0] ? TG_G_ADD : TG_E_ADD;
				r.value = 32'(half);
			end
			S_CALO4: begin
				r.tag   = i[0] ? TG_LPI0_ADD : TG_GPI0_ADD;
				r.value = 32'(half);
			end
			S_CALO5: begin
				unique case (i)
					4'd0:    begin r.tag = TG_H_ADD;        r.value = 32'(w[15:0]);  end
					4'd1:    begin r.tag = TG_PU_PEAK1_POS; r.value = 32'(w[23:16]); end
					default: begin r.tag = TG_PU_PEAK2_POS; r.value = 32'(w[31:24]); end
				endcase
			end
			S_PREV_SUMET: begin
				r.tag      = TG_SUM_ET;
				r.value    = 32'(half[13:0]);
				r.crossing = k[2:0] - {1'b0, e.pc};
			end
			S_NEXT_SUMET: begin
				r.tag      = TG_SUM_ET;
				r.value    = 32'(half[13:0]);
				r.crossing = k[2:0] + 3'd1;
			end
			default: ;
		endcase
		return r;
	endfunction

	assign cnt_w     = cnt_f(cur_q);
	assign res_w     = res_f(cur_q, idx_q);
	assign emit      = cur_v_q && (!out_v_q || out_ready);
	assign fin       = emit && (idx_q == cnt_w - 1'b1);
	assign pop_ready = !cur_v_q || fin;

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_q <= pop_data;
		end
		if (emit) begin
			out_res_q <= res_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q    <= 1'b0;
			idx_q      <= '0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				cur_v_q <= 1'b1;
				idx_q   <= '0;
			end else if (fin) begin
				cur_v_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit) begin
				out_v_q    <= 1'b1;
				out_last_q <= fin;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_res_q;
	assign out_last  = out_last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> (idx_q < cnt_w))
		else $error("record index past end of word");

	a_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (out_last_q == $past(idx_q == cnt_w - 1'b1)))
		else $error("tlast does not mark final record of word");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_v_q && cur_q.kind == K_ERR) |-> (cnt_w == 4'd1))
		else $error("error word must expand to one record");

	a_pop_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_v_q && !fin) |-> !pop_ready)
		else $error("entry replaced before all records sent");

endmodule

FILE: bench/tb_trigger_bank_word_deframer_top.sv
// ----------------------------------------------------------------------------
// tb_trigger_bank_word_deframer_top: self-checking bench for the bank deframer
// Feeds whole, truncated and malformed trigger banks word by word, predicts
// every tagged field record in order and compares each output transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trigger_bank_word_deframer_top;
	import tbwd_pkg::*;

	typedef struct {
		logic [31:0] word;
		logic        first;
		logic [15:0] bytes;
		logic [7:0]  ver;
	} bank_word_t;

	typedef struct {
		logic [5:0]  tag;
		logic [31:0] value;
		logic [2:0]  slot;
		logic [2:0]  xing;
		logic [2:0]  status;
		logic        last;
	} field_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;

	bank_word_t  pending_words[$];
	field_rec_t  expected_fields[$];
	int          errors = 0;
	int          words_queued = 0;
	bit          quiet = 1'b0;
	int          src_gap = 0;
	int          sink_stall = 0;
	int          idle_cycles = 0;

	// deframer state mirror
	logic [4:0]  sec = S_IDLE;
	logic [3:0]  sub = '0;
	logic [2:0]  xc = '0;
	logic [1:0]  tc = '0, cc = '0, pc = '0, nc = '0;
	logic [3:0]  mc = '0;
	logic [6:0]  mu1_pt = '0;
	logic [6:0]  bcid_mu = '0;
	logic [15:0] len_bytes = '0;
	logic [2:0]  mu_ids [8];
	int          n_fields;

	trigger_bank_word_deframer_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// bank length in bytes implied by the header counts
	function automatic int bank_size(int t, int c, int p, int n, int m);
		int pga2, pga3;
		pga2 = 4 * (7 + c + 2 * t + (t + c) * (p + n) + (p + 1) / 2 + (n + 1) / 2);
		pga3 = 4 * (4 + (m + 3) / 4 + (m + 1) / 2);
		return 4 + pga2 + pga3;
	endfunction

	function automatic int bank_words(int t, int c, int p, int n, int m);
		return bank_size(t, c, p, n, m) / 4;
	endfunction

	task automatic add_field(input logic [5:0] tag, input logic [31:0] value,
			input logic [2:0] slot, input int xing, input logic [2:0] status);
		field_rec_t r;
		r.tag = tag; r.value = value; r.slot = slot;
		r.xing = xing[2:0]; r.status = status; r.last = 1'b0;
		expected_fields.push_back(r);
		n_fields++;
	endtask

	// move to a section, skipping sections that take no words
	task automatic enter_section(input logic [4:0] s);
		bit done;
		done = 1'b0;
		while (!done) begin
			sub = '0;
			done = 1'b1;
			case (s)
				S_MUIN_ADD, S_MUIN_PT: if (mc == 0) begin s = S_PGA2HDR; done = 1'b0; end
				S_PREDEC, S_DEC: if (tc == 0) begin s = s + 5'd1; done = 1'b0; end
				S_COND: if (cc == 0) begin s = S_CALO0; done = 1'b0; end
				S_PREV_DEC: begin
					if (xc == 0) begin s = S_PREV_SUMET; done = 1'b0; end
					else if (tc == 0) begin s = S_PREV_COND; done = 1'b0; end
				end
				S_PREV_COND: if (cc == 0) begin xc--; s = S_PREV_DEC; done = 1'b0; end
				S_PREV_SUMET: if (pc == 0) begin xc = 3'd1; s = S_NEXT_DEC; done = 1'b0; end
				S_NEXT_DEC: begin
					if (xc > nc) begin s = S_NEXT_SUMET; done = 1'b0; end
					else if (tc == 0) begin s = S_NEXT_COND; done = 1'b0; end
				end
				S_NEXT_COND: if (cc == 0) begin xc++; s = S_NEXT_DEC; done = 1'b0; end
				S_NEXT_SUMET: if (nc == 0) s = S_IDLE;
				default: ;
			endcase
		end
		sec = s;
	endtask

	// expected records for one accepted word
	task automatic deframe_word(input logic [31:0] w, input logic first,
			input logic [15:0] bytes, input logic [7:0] ver);
		int k, sz;
		logic [15:0] h16;
		logic [7:0] b8;
		logic [11:0] bc;
		n_fields = 0;
		if (first) begin
			len_bytes = bytes;
			if (ver != GOOD_VERSION) begin
				add_field(TG_ERROR, ver, 0, 0, ST_VERSION);
				sec = S_IDLE;
			end else begin
				tc = w[1:0]; cc = w[3:2]; pc = w[13:12]; nc = w[15:14];
				mc = '0; sub = '0; xc = '0;
				add_field(TG_TRIG_COUNT, tc, 0, 0, ST_OK);
				add_field(TG_COND_COUNT, cc, 0, 0, ST_OK);
				add_field(TG_PGA_VERSION, w[11:4], 0, 0, ST_OK);
				add_field(TG_PREV_COUNT, pc, 0, 0, ST_OK);
				add_field(TG_NEXT_COUNT, nc, 0, 0, ST_OK);
				add_field(TG_TCK, w[31:16], 0, 0, ST_OK);
				sec = S_MUHDR;
			end
		end else begin
			case (sec)
				S_MUHDR: begin
					if (w[31:28] > 4'(MAX_MUONS_DEF)) begin
						add_field(TG_ERROR, w[31:28], 0, 0, ST_MUONS);
						sec = S_IDLE;
					end else begin
						mc = w[31:28];
						bcid_mu = w[27:21];
						add_field(TG_CU0, w[3:0], 0, 0, ST_OK);
						add_field(TG_CU1, w[7:4], 0, 0, ST_OK);
						add_field(TG_CU2, w[11:8], 0, 0, ST_OK);
						add_field(TG_CU3, w[15:12], 0, 0, ST_OK);
						add_field(TG_BCID_MUON, bcid_mu, 0, 0, ST_OK);
						add_field(TG_MUON_COUNT, mc, 0, 0, ST_OK);
						sec = S_MUPT;
					end
				end
				S_MUPT: begin
					mu1_pt = w[6:0];
					add_field(TG_MU1_PT, mu1_pt, 0, 0, ST_OK);
					add_field(TG_MU1_SGN, w[7], 0, 0, ST_OK);
					add_field(TG_MU2_PT, w[14:8], 0, 0, ST_OK);
					add_field(TG_MU2_SGN, w[15], 0, 0, ST_OK);
					add_field(TG_MU3_PT, w[22:16], 0, 0, ST_OK);
					add_field(TG_MU3_SGN, w[23], 0, 0, ST_OK);
					add_field(TG_DIMU_PT, w[31:24], 0, 0, ST_OK);
					add_field(TG_DIMU_PROD, 32'(mu1_pt) * 32'(w[14:8]), 0, 0, ST_OK);
					sec = S_MUADD12;
				end
				S_MUADD12: begin
					add_field(TG_MU1_ADD, w[15:0], 0, 0, ST_OK);
					add_field(TG_MU2_ADD, w[31:16], 0, 0, ST_OK);
					sec = S_MUADD3;
				end
				S_MUADD3: begin
					add_field(TG_MU3_ADD, w[15:0], 0, 0, ST_OK);
					add_field(TG_CLEAN, w[23:16], 0, 0, ST_OK);
					enter_section(S_MUIN_ADD);
				end
				S_MUIN_ADD: begin
					for (int h = 0; h < 2; h++) begin
						k = 2 * sub + h;
						if (k < mc) begin
							h16 = w[16*h +: 16];
							mu_ids[k] = h16[15:13];
							add_field(TG_MUIN_ADD, h16, h16[15:13], 0, ST_OK);
						end
					end
					sub++;
					if (2 * sub >= mc) enter_section(S_MUIN_PT);
				end
				S_MUIN_PT: begin
					for (int h = 0; h < 4; h++) begin
						k = 4 * sub + h;
						if (k < mc) begin
							b8 = w[8*h +: 8];
							add_field(TG_MUIN_PT, b8[6:0], mu_ids[k], 0, ST_OK);
							add_field(TG_MUIN_SGN, b8[7], mu_ids[k], 0, ST_OK);
						end
					end
					sub++;
					if (4 * sub >= mc) enter_section(S_PGA2HDR);
				end
				S_PGA2HDR: begin
					bc = {w[29:28], w[9:0]};
					add_field(TG_PGA2_STATUS, w[27:16], 0, 0, ST_OK);
					add_field(TG_DECISION_BITS, w[14:10], 0, 0, ST_OK);
					add_field(TG_BCID, bc, 0, 0, (bc[6:0] != bcid_mu) ? ST_BCID : ST_OK);
					sz = bank_size(tc, cc, pc, nc, mc);
					add_field(TG_BANK_SIZE, sz, 0, 0, (sz != len_bytes) ? ST_SIZE : ST_OK);
					enter_section(S_PREDEC);
				end
				S_PREDEC, S_DEC: begin
					add_field((sec == S_PREDEC) ? TG_PREDEC_SUM : TG_DEC_SUM, w, sub, 0, ST_OK);
					sub++;
					if (sub >= tc) enter_section(sec + 5'd1);
				end
				S_COND: begin
					add_field(TG_COND_SUM, w, sub, 0, ST_OK);
					sub++;
					if (sub >= cc) enter_section(S_CALO0);
				end
				S_CALO0: begin
					add_field(TG_SUM_ET, w[13:0], 0, 0, ST_OK);
					add_field(TG_SPD_MULT, w[27:14], 0, 0, ST_OK);
					add_field(TG_PU_MORE, w[31:28], 0, 0, ST_OK);
					sec = S_CALO1;
				end
				S_CALO1: begin
					add_field(TG_E_ET, w[7:0], 0, 0, ST_OK);
					add_field(TG_G_ET, w[15:8], 0, 0, ST_OK);
					add_field(TG_GPI0_ET, w[23:16], 0, 0, ST_OK);
					add_field(TG_LPI0_ET, w[31:24], 0, 0, ST_OK);
					sec = S_CALO2;
				end
				S_CALO2: begin
					add_field(TG_H_ET, w[7:0], 0, 0, ST_OK);
					add_field(TG_PU_PEAK1, w[15:8], 0, 0, ST_OK);
					add_field(TG_PU_PEAK2, w[23:16], 0, 0, ST_OK);
					add_field(TG_PU_HITS, w[31:24], 0, 0, ST_OK);
					sec = S_CALO3;
				end
				S_CALO3: begin
					add_field(TG_E_ADD, w[15:0], 0, 0, ST_OK);
					add_field(TG_G_ADD, w[31:16], 0, 0, ST_OK);
					sec = S_CALO4;
				end
				S_CALO4: begin
					add_field(TG_GPI0_ADD, w[15:0], 0, 0, ST_OK);
					add_field(TG_LPI0_ADD, w[31:16], 0, 0, ST_OK);
					sec = S_CALO5;
				end
				S_CALO5: begin
					add_field(TG_H_ADD, w[15:0], 0, 0, ST_OK);
					add_field(TG_PU_PEAK1_POS, w[23:16], 0, 0, ST_OK);
					add_field(TG_PU_PEAK2_POS, w[31:24], 0, 0, ST_OK);
					xc = {1'b0, pc};
					enter_section(S_PREV_DEC);
				end
				S_PREV_DEC: begin
					add_field(TG_DEC_SUM, w, sub, -int'(xc), ST_OK);
					sub++;
					if (sub >= tc) enter_section(S_PREV_COND);
				end
				S_PREV_COND: begin
					add_field(TG_COND_SUM, w, sub, -int'(xc), ST_OK);
					sub++;
					if (sub >= cc) begin xc--; enter_section(S_PREV_DEC); end
				end
				S_PREV_SUMET: begin
					for (int h = 0; h < 2; h++) begin
						k = 2 * sub + h;
						if (k < pc) add_field(TG_SUM_ET, w[16*h +: 14], 0, -(int'(pc) - k), ST_OK);
					end
					sub++;
					if (2 * sub >= pc) begin xc = 3'd1; enter_section(S_NEXT_DEC); end
				end
				S_NEXT_DEC: begin
					add_field(TG_DEC_SUM, w, sub, int'(xc), ST_OK);
					sub++;
					if (sub >= tc) enter_section(S_NEXT_COND);
				end
				S_NEXT_COND: begin
					add_field(TG_COND_SUM, w, sub, int'(xc), ST_OK);
					sub++;
					if (sub >= cc) begin xc++; enter_section(S_NEXT_DEC); end
				end
				S_NEXT_SUMET: begin
					for (int h = 0; h < 2; h++) begin
						k = 2 * sub + h;
						if (k < nc) add_field(TG_SUM_ET, w[16*h +: 14], 0, k + 1, ST_OK);
					end
					sub++;
					if (2 * sub >= nc) sec = S_IDLE;
				end
				default: ;  // idle: word dropped
			endcase
		end
		if (n_fields > 0) expected_fields[$].last = 1'b1;
	endtask

	task automatic queue_word(input logic [31:0] w, input logic first,
			input logic [15:0] bytes, input logic [7:0] ver);
		bank_word_t bw;
		bw.word = w; bw.first = first; bw.bytes = bytes; bw.ver = ver;
		pending_words.push_back(bw);
		words_queued++;
	endtask

	// Well-formed bank with random content. keep < 0 sends it whole, otherwise
	// at most that many words. bad_len and bad_bcid inject the two soft errors.
	task automatic queue_bank(input int t, input int c, input int p, input int n, input int m,
			input bit bad_len, input bit bad_bcid, input int keep);
		int nw, sz;
		logic [31:0] w;
		logic [6:0] bcid;
		logic [15:0] blen;
		nw = bank_words(t, c, p, n, m);
		sz = bank_size(t, c, p, n, m);
		if (keep >= 0 && keep < nw) nw = keep;
		bcid = 7'($urandom);
		blen = bad_len ? 16'($urandom) : 16'(sz);
		for (int i = 0; i < nw; i++) begin
			w = $urandom;
			if (i == 0) begin
				w[1:0] = 2'(t); w[3:2] = 2'(c); w[13:12] = 2'(p); w[15:14] = 2'(n);
				queue_word(w, 1'b1, blen, GOOD_VERSION);
			end else begin
				if (i == 1) begin w[31:28] = 4'(m); w[27:21] = bcid; end
				// status word follows header, muon block and per-muon inputs
				if (i == 5 + (m + 1) / 2 + (m + 3) / 4 && !bad_bcid) w[6:0] = bcid;
				queue_word(w, 1'b0, 16'($urandom), 8'($urandom));
			end
		end
	endtask

	// source side: one transfer per accepted s_ handshake, random gaps
	always @(posedge clk or negedge arst_n) begin
		bank_word_t bw;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				bw = pending_words.pop_front();
				s_tdata <= {bw.ver, bw.bytes, bw.word};
				s_tuser <= bw.first;
				s_tvalid <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 13);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_stall > 0) begin
			sink_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 6) == 0) sink_stall = $urandom_range(1, 13);
		end
	end

	// input monitor: predict from each accepted word
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			deframe_word(s_tdata[31:0], s_tuser, s_tdata[47:32], s_tdata[55:48]);
	end

	// output monitor: compare each record transfer with the oldest expectation
	always @(posedge clk) begin
		field_rec_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_fields.size() == 0) begin
				report($sformatf("unexpected record tag %0d value %h", m_tdata[5:0], m_tdata[37:6]));
			end else begin
				e = expected_fields.pop_front();
				if (m_tdata[5:0] !== e.tag)
					report($sformatf("tag %0d, want %0d", m_tdata[5:0], e.tag));
				if (m_tdata[37:6] !== e.value)
					report($sformatf("tag %0d value %h, want %h", e.tag, m_tdata[37:6], e.value));
				if (m_tdata[40:38] !== e.slot)
					report($sformatf("tag %0d slot %0d, want %0d", e.tag, m_tdata[40:38], e.slot));
				if (m_tdata[43:41] !== e.xing)
					report($sformatf("tag %0d crossing %0d, want %0d", e.tag,
						$signed(m_tdata[43:41]), $signed(e.xing)));
				if (m_tdata[46:44] !== e.status)
					report($sformatf("tag %0d status %0d, want %0d", e.tag, m_tdata[46:44], e.status));
				if (m_tdata[47] !== 1'b0)
					report($sformatf("tag %0d pad bit set", e.tag));
				if (m_tlast !== e.last)
					report($sformatf("tag %0d last %b, want %b", e.tag, m_tlast, e.last));
			end
		end
	end

	// watchdog: too long without any transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int r, t, c, p, n, m;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle word, both version extremes, too many muons,
		// the smallest bank, then a bank cut short by a new first word
		queue_word(32'hFFFF_FFFF, 1'b0, 16'hFFFF, 8'hFF);
		queue_word(32'h0000_0000, 1'b1, 16'h0000, 8'h00);
		queue_word(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'hFF);
		queue_word(32'h0000_0000, 1'b0, 16'h0000, 8'h00);
		queue_word(32'hFFFF_0FF0, 1'b1, 16'd48, GOOD_VERSION);
		queue_word(32'hF000_0000, 1'b0, 16'h0000, 8'h00);
		queue_bank(0, 0, 0, 0, 0, 1'b0, 1'b0, -1);
		queue_bank(1, 1, 1, 1, 2, 1'b1, 1'b1, 5);
		queue_word(32'h1234_5678, 1'b0, 16'h0000, 8'h00);

		// random: mostly whole banks, the first one at every maximum
		queue_bank(3, 3, 3, 3, MAX_MUONS_DEF, 1'b0, 1'b0, -1);
		while (words_queued < 100) begin
			r = $urandom_range(0, 11);
			t = $urandom_range(0, 3); c = $urandom_range(0, 3);
			p = $urandom_range(0, 2); n = $urandom_range(0, 2);
			m = $urandom_range(0, MAX_MUONS_DEF);
			case (r)
				0: queue_word($urandom, 1'b1, 16'($urandom), 8'($urandom_range(3, 255)));
				1: begin
					queue_word($urandom, 1'b1, 16'($urandom), GOOD_VERSION);
					queue_word({4'($urandom_range(MAX_MUONS_DEF + 1, 15)), 28'($urandom)},
						1'b0, 16'($urandom), 8'($urandom));
				end
				2: queue_bank(t, c, p, n, m, $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(1, bank_words(t, c, p, n, m) - 1));
				3: queue_word($urandom, 1'b0, 16'($urandom), 8'($urandom));
				default: queue_bank(t, c, p, n, m, $urandom_range(0, 3) == 0,
					$urandom_range(0, 3) == 0, -1);
			endcase
		end

		while (pending_words.size() > 25) @(negedge clk);
		quiet = 1'b1;
		while (pending_words.size() > 0 || s_tvalid || expected_fields.size() > 0)
			@(negedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
